// ===== rtl/ibhq_pkg.sv =====
package ibhq_pkg;

    localparam int ELEM_W        = 10;
    localparam int ELEMENTS      = 1 << ELEM_W;
    localparam int REQ_W         = 3;
    localparam int IN_COST_W     = 32;
    localparam int STATUS_W      = 2;
    localparam int CNT_OUT_W     = 11;
    localparam int MARK_W        = 2;
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_COST_BITS = 32;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_GONE  = 2'd3;

    localparam logic [MARK_W-1:0] MARK_NEW    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_QUEUED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE   = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]            req_type;
        logic [ELEM_W-1:0]           element;
        logic signed [IN_COST_W-1:0] cost_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [ELEM_W-1:0]           top_element;
        logic signed [IN_COST_W-1:0] top_cost;
        logic [CNT_OUT_W-1:0]        queued_count;
        logic                        is_empty;
        logic                        is_full;
    } t_rsp;

endpackage

// ===== rtl/ibhq_if.sv =====
interface ibhq_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [ibhq_pkg::REQ_W-1:0]               req_type;
    logic [ibhq_pkg::ELEM_W-1:0]              element;
    logic signed [ibhq_pkg::IN_COST_W-1:0]    cost_value;

    modport source (output valid, output req_type, output element, output cost_value,
                    input ready);
    modport sink   (input valid, input req_type, input element, input cost_value,
                    output ready);
endinterface

interface ibhq_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic [ibhq_pkg::STATUS_W-1:0]            status;
    logic [ibhq_pkg::ELEM_W-1:0]              top_element;
    logic signed [ibhq_pkg::IN_COST_W-1:0]    top_cost;
    logic [ibhq_pkg::CNT_OUT_W-1:0]           queued_count;
    logic                                     is_empty;
    logic                                     is_full;

    modport source (output valid, output status, output top_element, output top_cost,
                    output queued_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input top_element, input top_cost,
                    input queued_count, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/ibhq_ram.sv =====
module ibhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/ibhq_ctrl.sv =====
module ibhq_ctrl #(
    parameter int CAPACITY  = ibhq_pkg::DEF_CAPACITY,
    parameter int COST_BITS = ibhq_pkg::DEF_COST_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  logic           i_start,
    input  ibhq_pkg::t_req i_req,
    input  logic           i_take,
    output logic           o_idle,
    output logic           o_done,
    output ibhq_pkg::t_rsp o_rsp
);

    localparam int EW   = ibhq_pkg::ELEM_W;
    localparam int MW   = ibhq_pkg::MARK_W;
    localparam int SLW  = $clog2(CAPACITY);
    localparam int LW   = SLW + 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam longint SAT_HI = (longint'(1) << (COST_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_UPD1 = 5'd1;
    localparam logic [4:0] S_DEL1 = 5'd2;
    localparam logic [4:0] S_DEL2 = 5'd3;
    localparam logic [4:0] S_UP0  = 5'd4;
    localparam logic [4:0] S_UP1  = 5'd5;
    localparam logic [4:0] S_UP2  = 5'd6;
    localparam logic [4:0] S_UPW  = 5'd7;
    localparam logic [4:0] S_TOP1 = 5'd8;
    localparam logic [4:0] S_TOP2 = 5'd9;
    localparam logic [4:0] S_TOP3 = 5'd10;
    localparam logic [4:0] S_DN0  = 5'd11;
    localparam logic [4:0] S_DN1  = 5'd12;
    localparam logic [4:0] S_DN2  = 5'd13;
    localparam logic [4:0] S_DN3  = 5'd14;
    localparam logic [4:0] S_DN4  = 5'd15;
    localparam logic [4:0] S_DNW  = 5'd16;
    localparam logic [4:0] S_CLR  = 5'd17;
    localparam logic [4:0] S_DONE = 5'd18;

    // control registers
    logic [4:0]      r_state, n_state;
    logic            r_max;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [EW-1:0]   r_clr, n_clr;
    logic            r_clr_rst, n_clr_rst;

    // payload registers
    logic [ibhq_pkg::REQ_W-1:0]           r_type, n_type;
    logic [SLW-1:0]                       r_i, n_i;
    logic [SLW-1:0]                       r_s, n_s;
    logic [SLW-1:0]                       r_bj, n_bj;
    logic [EW-1:0]                        r_x, n_x;
    logic [EW-1:0]                        r_pe, n_pe;
    logic [EW-1:0]                        r_le, n_le;
    logic [EW-1:0]                        r_re, n_re;
    logic [EW-1:0]                        r_be, n_be;
    logic signed [COST_BITS-1:0]          r_cx, n_cx;
    logic signed [COST_BITS-1:0]          r_bc, n_bc;
    logic [ibhq_pkg::STATUS_W-1:0]        r_status, n_status;
    logic [EW-1:0]                        r_top_e, n_top_e;
    logic signed [ibhq_pkg::IN_COST_W-1:0] r_top_c, n_top_c;

    // memory ports
    logic                 w_heap_we;
    logic [SLW-1:0]       w_heap_wa, w_heap_ra;
    logic [EW-1:0]        w_heap_wd, w_heap_rd;
    logic                 w_slot_we;
    logic [EW-1:0]        w_slot_wa, w_slot_ra;
    logic [SLW-1:0]       w_slot_wd, w_slot_rd;
    logic                 w_mark_we;
    logic [EW-1:0]        w_mark_wa, w_mark_ra;
    logic [MW-1:0]        w_mark_wd, w_mark_rd;
    logic                 w_cost_we;
    logic [EW-1:0]        w_cost_wa, w_cost_ra;
    logic [COST_BITS-1:0] w_cost_wd, w_cost_rdata;
    logic signed [COST_BITS-1:0] w_cost_rd;

    logic signed [63:0]          w_in64, w_clamp;
    logic signed [COST_BITS-1:0] w_sat;
    logic signed [COST_BITS-1:0] w_cmp_a, w_cmp_b;
    logic                        w_cmp;
    logic [SLW-1:0]              w_par;
    logic [LW-1:0]               w_l, w_r, w_cnt_l;
    logic                        w_full, w_forced;
    logic [EW-1:0]               w_top;

    ibhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(w_heap_we), .i_waddr(w_heap_wa), .i_wdata(w_heap_wd),
        .i_raddr(w_heap_ra), .o_rdata(w_heap_rd));
    ibhq_ram #(.WIDTH(SLW), .DEPTH(ibhq_pkg::ELEMENTS)) u_slot (
        .i_clk(i_clk), .i_we(w_slot_we), .i_waddr(w_slot_wa), .i_wdata(w_slot_wd),
        .i_raddr(w_slot_ra), .o_rdata(w_slot_rd));
    ibhq_ram #(.WIDTH(MW), .DEPTH(ibhq_pkg::ELEMENTS)) u_mark (
        .i_clk(i_clk), .i_we(w_mark_we), .i_waddr(w_mark_wa), .i_wdata(w_mark_wd),
        .i_raddr(w_mark_ra), .o_rdata(w_mark_rd));
    ibhq_ram #(.WIDTH(COST_BITS), .DEPTH(ibhq_pkg::ELEMENTS)) u_cost (
        .i_clk(i_clk), .i_we(w_cost_we), .i_waddr(w_cost_wa), .i_wdata(w_cost_wd),
        .i_raddr(w_cost_ra), .o_rdata(w_cost_rdata));

    assign w_cost_rd = w_cost_rdata;

    // saturate the incoming cost to the stored width
    always_comb begin
        w_in64 = longint'(i_req.cost_value);
        if (w_in64 > SAT_HI) begin
            w_clamp = SAT_HI;
        end else if (w_in64 < SAT_LO) begin
            w_clamp = SAT_LO;
        end else begin
            w_clamp = w_in64;
        end
        w_sat = COST_BITS'(w_clamp);
    end

    // the one shared compare unit: true when a must sit above b
    always_comb begin
        unique case (r_state)
            S_UP2: begin
                w_cmp_a = r_cx;
                w_cmp_b = w_cost_rd;
            end
            S_DN3: begin
                w_cmp_a = w_cost_rd;
                w_cmp_b = r_bc;
            end
            default: begin
                w_cmp_a = w_cost_rd;
                w_cmp_b = r_cx;
            end
        endcase
        w_cmp = r_max ? (w_cmp_a > w_cmp_b) : (w_cmp_a < w_cmp_b);
    end

    assign w_par    = SLW'((r_i - 1'b1) >> 1);
    assign w_l      = {r_i, 1'b1};
    assign w_r      = w_l + 1'b1;
    assign w_cnt_l  = LW'(r_cnt);
    assign w_full   = r_cnt >= CNTW'(CAPACITY);
    assign w_forced = r_type == ibhq_pkg::REQ_DELETE;
    assign w_top    = w_forced ? r_x : w_heap_rd;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_clr_rst = r_clr_rst;
        n_type    = r_type;
        n_i       = r_i;
        n_s       = r_s;
        n_bj      = r_bj;
        n_x       = r_x;
        n_pe      = r_pe;
        n_le      = r_le;
        n_re      = r_re;
        n_be      = r_be;
        n_cx      = r_cx;
        n_bc      = r_bc;
        n_status  = r_status;
        n_top_e   = r_top_e;
        n_top_c   = r_top_c;
        w_heap_we = 1'b0;
        w_heap_wa = r_i;
        w_heap_wd = r_x;
        w_heap_ra = '0;
        w_slot_we = 1'b0;
        w_slot_wa = r_x;
        w_slot_wd = r_i;
        w_slot_ra = i_req.element;
        w_mark_we = 1'b0;
        w_mark_wa = i_req.element;
        w_mark_wd = ibhq_pkg::MARK_QUEUED;
        w_mark_ra = i_req.element;
        w_cost_we = 1'b0;
        w_cost_wa = i_req.element;
        w_cost_wd = w_sat;
        w_cost_ra = w_heap_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_type   = i_req.req_type;
                    n_x      = i_req.element;
                    n_cx     = w_sat;
                    n_status = ibhq_pkg::ST_DONE;
                    n_top_e  = '0;
                    n_top_c  = '0;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        ibhq_pkg::REQ_INSERT: begin
                            if (w_full) begin
                                n_status = ibhq_pkg::ST_FULL;
                            end else begin
                                w_cost_we = 1'b1;
                                w_mark_we = 1'b1;
                                n_i       = SLW'(r_cnt);
                                n_cnt     = r_cnt + 1'b1;
                                n_state   = S_UP0;
                            end
                        end
                        ibhq_pkg::REQ_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ibhq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_TOP1;
                            end
                        end
                        ibhq_pkg::REQ_UPDATE: begin
                            w_cost_we = 1'b1;
                            n_state   = S_UPD1;
                        end
                        ibhq_pkg::REQ_DELETE: begin
                            if (r_cnt == '0) begin
                                n_status = ibhq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DEL1;
                            end
                        end
                        ibhq_pkg::REQ_RESET: begin
                            n_cnt     = '0;
                            n_clr     = '0;
                            n_clr_rst = 1'b0;
                            n_state   = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UPD1: begin
                n_state = S_DONE;
                if (w_mark_rd == ibhq_pkg::MARK_GONE) begin
                    n_status = ibhq_pkg::ST_GONE;
                end else if (w_mark_rd == ibhq_pkg::MARK_QUEUED) begin
                    if (LW'(w_slot_rd) < w_cnt_l) begin
                        n_i     = w_slot_rd;
                        n_state = S_UP0;
                    end
                end else if (w_full) begin
                    n_status = ibhq_pkg::ST_FULL;
                end else begin
                    w_mark_we = 1'b1;
                    w_mark_wa = r_x;
                    n_i       = SLW'(r_cnt);
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_UP0;
                end
            end
            S_DEL1: begin
                n_state = S_DONE;
                if (w_mark_rd == ibhq_pkg::MARK_GONE) begin
                    n_status = ibhq_pkg::ST_GONE;
                end else if (w_mark_rd == ibhq_pkg::MARK_QUEUED) begin
                    n_s       = w_slot_rd;
                    w_heap_ra = w_slot_rd;
                    n_state   = S_DEL2;
                end
            end
            S_DEL2: begin
                // climb from the slot only if it still holds this element; a stale slot entry ends the request
                if (LW'(r_s) < w_cnt_l && w_heap_rd == r_x) begin
                    n_i     = r_s;
                    n_state = S_UP0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP0: begin
                if (r_i == '0) begin
                    n_state = S_UPW;
                end else begin
                    w_heap_ra = w_par;
                    n_state   = S_UP1;
                end
            end
            S_UP1: begin
                n_pe = w_heap_rd;
                if (w_forced) begin
                    w_heap_we = 1'b1;
                    w_heap_wd = w_heap_rd;
                    w_slot_we = 1'b1;
                    w_slot_wa = w_heap_rd;
                    n_i       = w_par;
                    n_state   = S_UP0;
                end else begin
                    w_cost_ra = w_heap_rd;
                    n_state   = S_UP2;
                end
            end
            S_UP2: begin
                if (w_cmp) begin
                    // move the parent down into the hole
                    w_heap_we = 1'b1;
                    w_heap_wd = r_pe;
                    w_slot_we = 1'b1;
                    w_slot_wa = r_pe;
                    n_i       = w_par;
                    n_state   = S_UP0;
                end else begin
                    n_state = S_UPW;
                end
            end
            S_UPW: begin
                w_heap_we = 1'b1;
                w_slot_we = 1'b1;
                n_state   = w_forced ? S_TOP1 : S_DONE;
            end
            S_TOP1: begin
                w_mark_we = 1'b1;
                w_mark_wa = w_top;
                w_mark_wd = w_forced ? ibhq_pkg::MARK_NEW : ibhq_pkg::MARK_GONE;
                n_top_e   = w_top;
                n_cnt     = r_cnt - 1'b1;
                w_heap_ra = SLW'(r_cnt - 1'b1);
                w_cost_ra = w_top;
                n_state   = S_TOP2;
            end
            S_TOP2: begin
                n_x       = w_heap_rd;
                n_top_c   = w_forced ? '0 : ibhq_pkg::IN_COST_W'(longint'(w_cost_rd));
                w_cost_ra = w_heap_rd;
                n_state   = S_TOP3;
            end
            S_TOP3: begin
                n_cx    = w_cost_rd;
                n_i     = '0;
                n_state = S_DN0;
            end
            S_DN0: begin
                if (w_l >= w_cnt_l) begin
                    n_state = S_DNW;
                end else begin
                    w_heap_ra = SLW'(w_l);
                    n_state   = S_DN1;
                end
            end
            S_DN1: begin
                n_le      = w_heap_rd;
                w_cost_ra = w_heap_rd;
                w_heap_ra = SLW'(w_r);
                n_state   = S_DN2;
            end
            S_DN2: begin
                if (w_cmp) begin
                    n_bj = SLW'(w_l);
                    n_be = r_le;
                    n_bc = w_cost_rd;
                end else begin
                    n_bj = r_i;
                    n_be = r_x;
                    n_bc = r_cx;
                end
                if (w_r < w_cnt_l) begin
                    n_re      = w_heap_rd;
                    w_cost_ra = w_heap_rd;
                    n_state   = S_DN3;
                end else begin
                    n_state = S_DN4;
                end
            end
            S_DN3: begin
                if (w_cmp) begin
                    n_bj = SLW'(w_r);
                    n_be = r_re;
                    n_bc = w_cost_rd;
                end
                n_state = S_DN4;
            end
            S_DN4: begin
                if (r_bj == r_i) begin
                    n_state = S_DNW;
                end else begin
                    w_heap_we = 1'b1;
                    w_heap_wd = r_be;
                    w_slot_we = 1'b1;
                    w_slot_wa = r_be;
                    n_i       = r_bj;
                    n_state   = S_DN0;
                end
            end
            S_DNW: begin
                w_heap_we = 1'b1;
                w_slot_we = 1'b1;
                n_state   = S_DONE;
            end
            S_CLR: begin
                w_mark_we = 1'b1;
                w_mark_wa = r_clr;
                w_mark_wd = ibhq_pkg::MARK_NEW;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = r_clr_rst ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_clr     <= '0;
            r_clr_rst <= 1'b1;
            r_max     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_clr     <= n_clr;
            r_clr_rst <= n_clr_rst;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_i      <= n_i;
        r_s      <= n_s;
        r_bj     <= n_bj;
        r_x      <= n_x;
        r_pe     <= n_pe;
        r_le     <= n_le;
        r_re     <= n_re;
        r_be     <= n_be;
        r_cx     <= n_cx;
        r_bc     <= n_bc;
        r_status <= n_status;
        r_top_e  <= n_top_e;
        r_top_c  <= n_top_c;
    end

    assign o_idle = r_state == S_IDLE;
    assign o_done = r_state == S_DONE;

    always_comb begin
        o_rsp.status       = r_status;
        o_rsp.top_element  = r_top_e;
        o_rsp.top_cost     = r_top_c;
        o_rsp.queued_count = ibhq_pkg::CNT_OUT_W'(r_cnt);
        o_rsp.is_empty     = r_cnt == '0;
        o_rsp.is_full      = w_full;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(CAPACITY))
        else $error("heap count above capacity");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("request started while busy");

    a_done_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_take) |=> r_state == S_IDLE)
        else $error("result taken but sequencer did not return to idle");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_type == ibhq_pkg::REQ_RESET) |-> r_cnt == '0)
        else $error("heap not empty after reset of marks");

endmodule

// ===== rtl/indexed_binary_heap_queue.sv =====
// channel   dir  handshake      payload
// i_req     in   valid/ready    req_type, element, cost_value
// o_rsp     out  valid/ready    status, top_element, top_cost, queued_count, is_empty, is_full
// i_cfg     in   i_cfg_we       i_cfg_data (max_first)
//
// One request at a time; i_req.ready is high only while the sequencer is idle.
// Insert climbs the heap toward the root, comparing with each parent; update first reads the
// element's mark and slot. Remove takes the top, then sifts down (heap read, cost read per level).
// Delete forces the element up to the root, then removes it as the top and sifts down.
// Reset of marks sweeps the whole mark RAM. After i_rst_n the same sweep runs before the first
// request; a stalled o_rsp holds the sequencer in done.
module indexed_binary_heap_queue #(
    parameter int CAPACITY  = ibhq_pkg::DEF_CAPACITY,
    parameter int COST_BITS = ibhq_pkg::DEF_COST_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    ibhq_req_if.sink   i_req,
    ibhq_rsp_if.source o_rsp
);

    ibhq_pkg::t_req w_req;
    ibhq_pkg::t_rsp w_rsp;
    ibhq_pkg::t_rsp r_rsp;
    logic           r_out_valid;
    logic           w_idle, w_done, w_start, w_take;

    assign w_req.req_type   = i_req.req_type;
    assign w_req.element    = i_req.element;
    assign w_req.cost_value = i_req.cost_value;

    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;
    // advance only when the output register is free or being emptied
    assign w_take      = w_done && (!r_out_valid || o_rsp.ready);

    ibhq_ctrl #(.CAPACITY(CAPACITY), .COST_BITS(COST_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_start    (w_start),
        .i_req      (w_req),
        .i_take     (w_take),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.top_element  = r_rsp.top_element;
    assign o_rsp.top_cost     = r_rsp.top_cost;
    assign o_rsp.queued_count = r_rsp.queued_count;
    assign o_rsp.is_empty     = r_rsp.is_empty;
    assign o_rsp.is_full      = r_rsp.is_full;

endmodule
